// ----- rtl/brqg_pkg.sv -----
// Package for the Bezier surface-of-revolution quad generator.
// Holds shared types, register indexes, sizing constants and the sine/cosine table.
// Depends on nothing; every other file imports it.
`default_nettype none

package brqg_pkg;

  // Sizing constants.
  localparam int MAX_SEGMENTS     = 60;
  localparam int ANGLE_TABLE_BITS = 10;
  localparam int SEG_W            = 6;
  localparam int QTR              = 1 << (ANGLE_TABLE_BITS - 2);
  localparam int DIV_NUM_W        = 33;
  localparam int DIV_DEN_W        = 18;
  localparam int DIV_CNT_W        = $clog2(DIV_NUM_W + 1);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_CP0      = 3'd0;
  localparam logic [2:0] REG_CP1      = 3'd1;
  localparam logic [2:0] REG_CP2      = 3'd2;
  localparam logic [2:0] REG_CP3      = 3'd3;
  localparam logic [2:0] REG_SEGMENTS = 3'd4;
  localparam logic [2:0] REG_FILL     = 3'd5;

  // One classified cell waiting for the back end.
  typedef struct packed {
    logic [SEG_W-1:0] prof;
    logic [SEG_W-1:0] ang;
    logic [SEG_W-1:0] seg;
    logic             fill;
  } item_t;

  // Request and response of the shared divider.
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quotient;
  } div_rsp_t;

  // Back end sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WGT1,
    ST_WGT2,
    ST_MAC,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_SQ,
    ST_RINIT,
    ST_ROOT,
    ST_ROUND,
    ST_ANGGO,
    ST_ANGWAIT,
    ST_VMUL,
    ST_VOUT
  } back_state_t;

  typedef logic [QTR-1:0][31:0] trig_tab_t;

  // Q2.30 product with rounding to nearest.
  function automatic logic [63:0] mulq30(input logic [63:0] a, input logic [63:0] b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  // First-quadrant sine or cosine in Q2.30 from a Taylor series of order 13/12.
  function automatic trig_tab_t build_trig(input logic want_sin);
    trig_tab_t          tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        ts;
    logic [63:0]        tc;
    logic signed [63:0] s;
    logic signed [63:0] c;
    for (int r = 0; r < QTR; r++) begin
      x  = (64'(r) * HALF_PI_Q30) >> (ANGLE_TABLE_BITS - 2);
      x2 = mulq30(x, x);
      ts = x;
      s  = signed'(x);
      tc = ONE_Q30;
      c  = signed'(ONE_Q30);
      ts = mulq30(ts, x2) / 64'd6;   tc = mulq30(tc, x2) / 64'd2;
      s  = s - signed'(ts);          c  = c - signed'(tc);
      ts = mulq30(ts, x2) / 64'd20;  tc = mulq30(tc, x2) / 64'd12;
      s  = s + signed'(ts);          c  = c + signed'(tc);
      ts = mulq30(ts, x2) / 64'd42;  tc = mulq30(tc, x2) / 64'd30;
      s  = s - signed'(ts);          c  = c - signed'(tc);
      ts = mulq30(ts, x2) / 64'd72;  tc = mulq30(tc, x2) / 64'd56;
      s  = s + signed'(ts);          c  = c + signed'(tc);
      ts = mulq30(ts, x2) / 64'd110; tc = mulq30(tc, x2) / 64'd90;
      s  = s - signed'(ts);          c  = c - signed'(tc);
      ts = mulq30(ts, x2) / 64'd156; tc = mulq30(tc, x2) / 64'd132;
      s  = s + signed'(ts);          c  = c + signed'(tc);
      tab[r] = want_sin ? s[31:0] : c[31:0];
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = build_trig(1'b1);
  localparam trig_tab_t COS_TAB = build_trig(1'b0);

endpackage

`default_nettype wire

// ----- rtl/brqg_front.sv -----
// Front end: accepts cell commands, drops out-of-range cells, queues the rest.
// Depends on brqg_pkg for the item type and segment limit.
`default_nettype none

module brqg_front import brqg_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [SEG_W-1:0] profile_step,
  input  wire logic [SEG_W-1:0] angle_step,
  input  wire logic [SEG_W-1:0] segments,
  input  wire logic             fill_mode,
  input  wire logic             pop,
  output logic                  head_valid,
  output item_t                 head
);

  item_t            q_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r;
  logic [SEG_W-1:0] seg_eff;
  logic             in_range;
  logic             push;
  logic             do_pop;

  // Clamp the grid size and check that the cell lies on the grid.
  always_comb begin
    seg_eff  = (segments > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : segments;
    in_range = (profile_step < seg_eff) && (angle_step < seg_eff);
  end

  assign busy       = (cnt_r == 2'd2);
  assign push       = start && !busy && in_range;
  assign head_valid = (cnt_r != 2'd0);
  assign do_pop     = pop && head_valid;
  assign head       = q_r[rd_ptr_r];

  // Two-entry queue toward the back end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{prof: profile_step, ang: angle_step, seg: seg_eff, fill: fill_mode};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/brqg_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on brqg_pkg for the request and response structs.
`default_nettype none

module brqg_div import brqg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 run_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;
  logic                 ge;

  // One trial subtraction of the shifted remainder.
  always_comb begin
    trial = {rem_r, quo_r[DIV_NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= DIV_CNT_W'(DIV_NUM_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath of the divider.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      den_r <= req.divisor;
    end else if (run_r) begin
      rem_r <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo_r <= {quo_r[DIV_NUM_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// ----- rtl/brqg_back.sv -----
// Back end: evaluates the curve, radius and angles of one cell and emits four vertices.
// Depends on brqg_pkg; uses the shared divider through its request/response structs.
`default_nettype none

module brqg_back import brqg_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [3:0][47:0] ctrl_pt,
  input  wire logic             head_valid,
  input  wire item_t            head,
  output logic                  pop,
  output div_req_t              div_req,
  input  wire div_rsp_t         div_rsp,
  output logic                  out_strobe,
  output logic signed [19:0]    out_vertex_x,
  output logic signed [19:0]    out_vertex_y,
  output logic signed [19:0]    out_vertex_z,
  output logic [1:0]            out_corner,
  output logic                  out_filled,
  output logic                  out_last
);

  back_state_t state_r, state_nxt;

  item_t              item_r;
  logic               pt_r;
  logic [1:0]         lane_r;
  logic [1:0]         mac_k_r;
  logic               ang_a_r;
  logic [1:0]         vtx_r;
  logic [3:0]         root_cnt_r;
  logic [SEG_W-1:0]   p_r;
  logic [SEG_W-1:0]   m_r;
  logic [11:0]        mm_r;
  logic [11:0]        pp_r;
  logic [11:0]        nn_r;
  logic [17:0]        w_r [4];
  logic [17:0]        n3_r;
  logic signed [34:0] acc_r;
  logic               neg_r;
  logic signed [16:0] crd_r [3];
  logic [31:0]        sqx_r;
  logic [31:0]        sqy_r;
  logic [31:0]        rs_r;
  logic [31:0]        rr_r;
  logic [31:0]        rbit_r;
  logic [16:0]        rad_r [2];
  logic signed [16:0] hgt_r [2];
  logic signed [31:0] co_r [2];
  logic signed [31:0] si_r [2];
  logic signed [49:0] px_r;
  logic signed [49:0] py_r;
  logic               strobe_r;
  logic signed [19:0] ox_r;
  logic signed [19:0] oy_r;
  logic signed [19:0] oz_r;
  logic [1:0]         oc_r;
  logic               of_r;
  logic               ol_r;

  logic [SEG_W-1:0]   p_w;
  logic [SEG_W-1:0]   ja_w;
  logic [17:0]        mmp_w;
  logic [17:0]        ppm_w;
  logic signed [15:0] coord_w;
  logic signed [34:0] prod_w;
  logic [34:0]        acc_mag_w;
  logic [15:0]        q16_w;
  logic signed [16:0] cq_w;
  logic [15:0]        ax_w;
  logic [15:0]        ay_w;
  logic [16:0]        abs_x_w;
  logic [16:0]        abs_y_w;
  logic [32:0]        trial_w;
  logic               take_w;
  logic [ANGLE_TABLE_BITS-1:0] k_w;
  logic [ANGLE_TABLE_BITS-3:0] kr_w;
  logic signed [31:0] s_tab_w;
  logic signed [31:0] c_tab_w;
  logic signed [31:0] co_w;
  logic signed [31:0] si_w;
  logic               psel_w;
  logic               asel_w;

  // Round a Q2.30-scaled product to the nearest integer, ties away from zero, and saturate.
  function automatic logic signed [19:0] rnd_sat(input logic signed [49:0] v);
    logic [49:0]        mag;
    logic [20:0]        rq;
    logic signed [21:0] sv;
    mag = v[49] ? 50'(-v) : 50'(v);
    rq  = 21'((mag + 50'd536870912) >> 30);
    sv  = v[49] ? -$signed({1'b0, rq}) : $signed({1'b0, rq});
    if (sv > 22'sd524287) begin
      return 20'sd524287;
    end else if (sv < -22'sd524288) begin
      return -20'sd524288;
    end else begin
      return sv[19:0];
    end
  endfunction

  // Arithmetic shared by the sequencer steps.
  always_comb begin
    p_w       = item_r.prof + SEG_W'(pt_r);
    ja_w      = item_r.ang + SEG_W'(ang_a_r);
    mmp_w     = 18'(mm_r * p_r);
    ppm_w     = 18'(pp_r * m_r);
    coord_w   = ctrl_pt[mac_k_r][16*lane_r +: 16];
    prod_w    = $signed({1'b0, w_r[mac_k_r]}) * coord_w;
    acc_mag_w = acc_r[34] ? 35'(-acc_r) : 35'(acc_r);
    q16_w     = div_rsp.quotient[15:0];
    cq_w      = neg_r ? -$signed({1'b0, q16_w}) : $signed({1'b0, q16_w});
    abs_x_w   = crd_r[0][16] ? 17'(-crd_r[0]) : 17'(crd_r[0]);
    abs_y_w   = crd_r[1][16] ? 17'(-crd_r[1]) : 17'(crd_r[1]);
    ax_w      = abs_x_w[15:0];
    ay_w      = abs_y_w[15:0];
    trial_w   = {1'b0, rr_r} + {1'b0, rbit_r};
    take_w    = ({1'b0, rs_r} >= trial_w);
    k_w       = div_rsp.quotient[ANGLE_TABLE_BITS-1:0];
    kr_w      = k_w[ANGLE_TABLE_BITS-3:0];
    s_tab_w   = SIN_TAB[kr_w];
    c_tab_w   = COS_TAB[kr_w];
    psel_w    = (vtx_r == 2'd1) || (vtx_r == 2'd2);
    asel_w    = vtx_r[1];
  end

  // Quadrant symmetry of the sine and cosine.
  always_comb begin
    unique case (k_w[ANGLE_TABLE_BITS-1:ANGLE_TABLE_BITS-2])
      2'd0: begin
        co_w = c_tab_w;
        si_w = s_tab_w;
      end
      2'd1: begin
        co_w = -s_tab_w;
        si_w = c_tab_w;
      end
      2'd2: begin
        co_w = -c_tab_w;
        si_w = -s_tab_w;
      end
      default: begin
        co_w = s_tab_w;
        si_w = -c_tab_w;
      end
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (head_valid) state_nxt = ST_WGT1;
      ST_WGT1:    state_nxt = ST_WGT2;
      ST_WGT2:    state_nxt = ST_MAC;
      ST_MAC:     if (mac_k_r == 2'd3) state_nxt = ST_DIVGO;
      ST_DIVGO:   state_nxt = ST_DIVWAIT;
      ST_DIVWAIT: begin
        if (div_rsp.done) state_nxt = (lane_r == 2'd2) ? ST_SQ : ST_MAC;
      end
      ST_SQ:      state_nxt = ST_RINIT;
      ST_RINIT:   state_nxt = ST_ROOT;
      ST_ROOT:    if (root_cnt_r == 4'd15) state_nxt = ST_ROUND;
      ST_ROUND:   state_nxt = pt_r ? ST_ANGGO : ST_WGT1;
      ST_ANGGO:   state_nxt = ST_ANGWAIT;
      ST_ANGWAIT: begin
        if (div_rsp.done) state_nxt = ang_a_r ? ST_VMUL : ST_ANGGO;
      end
      ST_VMUL:    state_nxt = ST_VOUT;
      ST_VOUT:    state_nxt = (vtx_r == 2'd3) ? ST_IDLE : ST_VMUL;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    pop              = (state_r == ST_IDLE) && head_valid;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state_r)
      ST_DIVGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_NUM_W'(acc_mag_w) + DIV_NUM_W'(n3_r >> 1);
        div_req.divisor  = n3_r;
      end
      ST_ANGGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_NUM_W'({ja_w, {ANGLE_TABLE_BITS{1'b0}}}) +
                           DIV_NUM_W'(item_r.seg >> 1);
        div_req.divisor  = DIV_DEN_W'(item_r.seg);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= (state_r == ST_VOUT);
    end
  end

  // Datapath registers, stepped by the sequencer.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        item_r <= head;
        pt_r   <= 1'b0;
      end
      ST_WGT1: begin
        p_r  <= p_w;
        m_r  <= item_r.seg - p_w;
        mm_r <= 12'((item_r.seg - p_w) * (item_r.seg - p_w));
        pp_r <= 12'(p_w * p_w);
        nn_r <= 12'(item_r.seg * item_r.seg);
      end
      ST_WGT2: begin
        w_r[0]  <= 18'(mm_r * m_r);
        w_r[1]  <= 18'({mmp_w, 1'b0} + 19'(mmp_w));
        w_r[2]  <= 18'({ppm_w, 1'b0} + 19'(ppm_w));
        w_r[3]  <= 18'(pp_r * p_r);
        n3_r    <= 18'(nn_r * item_r.seg);
        lane_r  <= 2'd0;
        mac_k_r <= 2'd0;
        acc_r   <= '0;
      end
      ST_MAC: begin
        acc_r   <= acc_r + prod_w;
        mac_k_r <= mac_k_r + 2'd1;
      end
      ST_DIVGO: begin
        neg_r <= acc_r[34];
      end
      ST_DIVWAIT: begin
        if (div_rsp.done) begin
          crd_r[lane_r] <= cq_w;
          lane_r        <= lane_r + 2'd1;
          mac_k_r       <= 2'd0;
          acc_r         <= '0;
        end
      end
      ST_SQ: begin
        sqx_r <= ax_w * ax_w;
        sqy_r <= ay_w * ay_w;
      end
      ST_RINIT: begin
        rs_r       <= sqx_r + sqy_r;
        rr_r       <= '0;
        rbit_r     <= 32'h4000_0000;
        root_cnt_r <= '0;
      end
      ST_ROOT: begin
        if (take_w) begin
          rs_r <= rs_r - trial_w[31:0];
          rr_r <= (rr_r >> 1) + rbit_r;
        end else begin
          rr_r <= rr_r >> 1;
        end
        rbit_r     <= rbit_r >> 2;
        root_cnt_r <= root_cnt_r + 4'd1;
      end
      ST_ROUND: begin
        rad_r[pt_r] <= 17'(rr_r + 32'(rs_r > rr_r));
        hgt_r[pt_r] <= crd_r[2];
        pt_r        <= 1'b1;
        ang_a_r     <= 1'b0;
      end
      ST_ANGGO: begin
      end
      ST_ANGWAIT: begin
        if (div_rsp.done) begin
          co_r[ang_a_r] <= co_w;
          si_r[ang_a_r] <= si_w;
          ang_a_r       <= 1'b1;
          vtx_r         <= 2'd0;
        end
      end
      ST_VMUL: begin
        px_r <= $signed({1'b0, rad_r[psel_w]}) * co_r[asel_w];
        py_r <= $signed({1'b0, rad_r[psel_w]}) * si_r[asel_w];
      end
      ST_VOUT: begin
        ox_r  <= rnd_sat(px_r);
        oy_r  <= rnd_sat(py_r);
        oz_r  <= 20'(hgt_r[psel_w]);
        oc_r  <= vtx_r;
        of_r  <= item_r.fill;
        ol_r  <= (vtx_r == 2'd3);
        vtx_r <= vtx_r + 2'd1;
      end
      default: begin
      end
    endcase
  end

  assign out_strobe   = strobe_r;
  assign out_vertex_x = ox_r;
  assign out_vertex_y = oy_r;
  assign out_vertex_z = oz_r;
  assign out_corner   = oc_r;
  assign out_filled   = of_r;
  assign out_last     = ol_r;

endmodule

`default_nettype wire

// ----- rtl/bezier_revolution_quad_gen_top.sv -----
// Top level of the Bezier surface-of-revolution quad generator.
// Depends on brqg_pkg, brqg_front, brqg_div and brqg_back.
//
// Usage: four control points, the grid size and the fill mode are written over the
// APB-style port (64-bit registers at byte addresses 0, 8, .. 40; reads return them).
// A cell command (in_profile_step, in_angle_step) is taken at an edge where start is
// high and busy is low. Cells off the grid are accepted and give no vertices. Each
// valid cell gives four vertex words, corners 0 to 3, each shown for one cycle with
// out_strobe high; out_last marks the fourth.
// The back end finishes one cell before it takes the next from the queue. The shared
// serial divider sets the pace: each cell needs eight divisions (six curve coordinates
// and two angles), besides two square roots and the four vertex words. Two commands
// can queue behind the one in progress, so busy only rises when that queue is full.
// Reset clears the queue and the sequencer and returns the registers to control
// points zero, five segments and outline mode. The receiver cannot stall: every
// word must be taken in the cycle it is shown.
`default_nettype none

module bezier_revolution_quad_gen_top import brqg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [5:0]  in_profile_step,
  input  wire logic [5:0]  in_angle_step,
  output logic             out_strobe,
  output logic signed [19:0] out_vertex_x,
  output logic signed [19:0] out_vertex_y,
  output logic signed [19:0] out_vertex_z,
  output logic [1:0]       out_corner,
  output logic             out_filled,
  output logic             out_last
);

  logic [3:0][47:0] cp_r;
  logic [5:0]       seg_r;
  logic             fill_r;
  logic             wr_en;
  logic [2:0]       reg_idx;
  logic             head_valid;
  item_t            head;
  logic             pop;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_r   <= '0;
      seg_r  <= 6'd5;
      fill_r <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CP0:      cp_r[0] <= pwdata[47:0];
        REG_CP1:      cp_r[1] <= pwdata[47:0];
        REG_CP2:      cp_r[2] <= pwdata[47:0];
        REG_CP3:      cp_r[3] <= pwdata[47:0];
        REG_SEGMENTS: seg_r   <= pwdata[5:0];
        REG_FILL:     fill_r  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_CP0:      prdata = {16'd0, cp_r[0]};
      REG_CP1:      prdata = {16'd0, cp_r[1]};
      REG_CP2:      prdata = {16'd0, cp_r[2]};
      REG_CP3:      prdata = {16'd0, cp_r[3]};
      REG_SEGMENTS: prdata = {58'd0, seg_r};
      REG_FILL:     prdata = {63'd0, fill_r};
      default:      prdata = '0;
    endcase
  end

  brqg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .profile_step (in_profile_step),
    .angle_step   (in_angle_step),
    .segments     (seg_r),
    .fill_mode    (fill_r),
    .pop          (pop),
    .head_valid   (head_valid),
    .head         (head)
  );

  brqg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  brqg_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl_pt      (cp_r),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .out_strobe   (out_strobe),
    .out_vertex_x (out_vertex_x),
    .out_vertex_y (out_vertex_y),
    .out_vertex_z (out_vertex_z),
    .out_corner   (out_corner),
    .out_filled   (out_filled),
    .out_last     (out_last)
  );

endmodule

`default_nettype wire

// ----- bench/bezier_revolution_quad_gen_top_test.sv -----
// Self-checking bench for the Bezier surface-of-revolution quad generator.
// Drives cell commands and register writes, and checks each vertex word against a predictor.
// Depends on brqg_pkg and the RTL top bezier_revolution_quad_gen_top.
`default_nettype none

module bezier_revolution_quad_gen_top_test;
  import brqg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_SPARE  = 3'd6;  // unmapped slot, writes are dropped
  localparam int         SETTLE     = 400;   // one cell plus margin, in cycles
  localparam int         QUIET_MAX  = 20000; // cycles with no traffic before giving up
  localparam int         PHASES     = 6;
  localparam int         PHASE_CELLS = 30;

  typedef struct {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
    logic [1:0]         corner;
    logic               filled;
    logic               last;
  } vertex_t;

  // One row of the directed part: a register write or a cell command.
  typedef struct {
    bit          is_write;
    logic [2:0]  idx;
    logic [63:0] data;
    logic [5:0]  prof;
    logic [5:0]  ang;
    bit          flat;  // all control points zero: every vertex sits at the origin
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [5:0]  in_profile_step = '0;
  logic [5:0]  in_angle_step = '0;
  logic        out_strobe;
  logic signed [19:0] out_vertex_x;
  logic signed [19:0] out_vertex_y;
  logic signed [19:0] out_vertex_z;
  logic [1:0]  out_corner;
  logic        out_filled;
  logic        out_last;

  // Shadow of the block's registers.
  logic [47:0] ctrl_pt [4];
  logic [5:0]  grid_n;
  logic        fill_on;

  vertex_t pending_vertices[$];
  int      errors = 0;
  int      quiet = 0;
  row_t    rows[$];

  bezier_revolution_quad_gen_top u_top (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .in_profile_step, .in_angle_step, .out_strobe,
    .out_vertex_x, .out_vertex_y, .out_vertex_z, .out_corner, .out_filled, .out_last
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Division rounded to nearest, ties away from zero.
  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint unsigned round_sqrt(longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (s > r) r = r + 1;
    return r;
  endfunction

  function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // Radius and height of the profile curve at t = i/n.
  task automatic profile_point(input longint i, input longint n,
                               output longint rad, output longint hgt);
    longint m;
    longint w [4];
    longint c [3];
    longint num;
    longint unsigned ax;
    longint unsigned ay;
    m = n - i;
    w[0] = m * m * m;
    w[1] = 3 * i * m * m;
    w[2] = 3 * i * i * m;
    w[3] = i * i * i;
    for (int l = 0; l < 3; l++) begin
      num = 0;
      for (int k = 0; k < 4; k++)
        num += w[k] * longint'($signed(ctrl_pt[k][16*l +: 16]));
      c[l] = round_div(num * 256, 256 * n * n * n);
    end
    ax = (c[0] < 0) ? -c[0] : c[0];
    ay = (c[1] < 0) ? -c[1] : c[1];
    rad = longint'(round_sqrt(ax * ax + ay * ay));
    hgt = c[2];
  endtask

  // Cosine and sine in Q2.30 of angle step j out of n.
  task automatic sweep_angle(input longint j, input longint n,
                             output longint co, output longint si);
    longint unsigned k;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned ts;
    longint unsigned tc;
    longint s;
    longint c;
    k = ((longint'(j) << ANGLE_TABLE_BITS) + n / 2) / n;
    k = k & ((64'd1 << ANGLE_TABLE_BITS) - 1);
    x = ((k & (QTR - 1)) * 64'd1686629713) >> (ANGLE_TABLE_BITS - 2);
    x2 = q30_mul(x, x);
    ts = x;
    s = x;
    tc = 64'd1 << 30;
    c = 64'd1 << 30;
    for (int t = 1; t <= 6; t++) begin
      ts = q30_mul(ts, x2) / ((2 * t) * (2 * t + 1));
      tc = q30_mul(tc, x2) / ((2 * t - 1) * (2 * t));
      if (t % 2 == 1) begin
        s -= ts;
        c -= tc;
      end else begin
        s += ts;
        c += tc;
      end
    end
    case (k >> (ANGLE_TABLE_BITS - 2))
      0: begin co = c;  si = s;  end
      1: begin co = -s; si = c;  end
      2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
  endtask

  function automatic logic signed [19:0] clip20(longint v);
    if (v > 524287) v = 524287;
    if (v < -524288) v = -524288;
    return v[19:0];
  endfunction

  // Queue the four corners of cell (i, j), or nothing if the cell is off the grid.
  task automatic predict_quad(input logic [5:0] i, input logic [5:0] j, input bit flat);
    longint n;
    longint rad [2];
    longint hgt [2];
    longint co [2];
    longint si [2];
    vertex_t v;
    int p;
    int a;
    n = (grid_n > MAX_SEGMENTS) ? MAX_SEGMENTS : grid_n;
    if (i >= n || j >= n) return;
    profile_point(i, n, rad[0], hgt[0]);
    profile_point(i + 1, n, rad[1], hgt[1]);
    sweep_angle(j, n, co[0], si[0]);
    sweep_angle(j + 1, n, co[1], si[1]);
    for (int c = 0; c < 4; c++) begin
      p = (c == 1 || c == 2);
      a = (c >= 2);
      v.x = flat ? '0 : clip20(round_div(rad[p] * co[a], 64'd1 << 30));
      v.y = flat ? '0 : clip20(round_div(rad[p] * si[a], 64'd1 << 30));
      v.z = flat ? '0 : clip20(hgt[p]);
      v.corner = c[1:0];
      v.filled = fill_on;
      v.last = (c == 3);
      pending_vertices.insert(pending_vertices.size(), v);
    end
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Lower start and wait until the block has drained.
  task automatic drain();
    start <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CP0, REG_CP1, REG_CP2, REG_CP3: ctrl_pt[idx] = data[47:0];
      REG_SEGMENTS: grid_n = data[5:0];
      REG_FILL: fill_on = data[0];
      default: ;
    endcase
    // Idle before returning, so that a following write starts on a later edge.
    @(posedge clk);
  endtask

  // Issue one cell; start stays high across back-to-back words.
  task automatic send_cell(input logic [5:0] i, input logic [5:0] j, input bit flat);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
    if (gap > 0 || !start) begin
      if (start) start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_profile_step <= i;
    in_angle_step <= j;
    do @(posedge clk); while (busy);
    predict_quad(i, j, flat);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic row_t wr_row(logic [2:0] idx, logic [63:0] data);
    row_t r;
    r = '{1'b1, idx, data, 6'd0, 6'd0, 1'b0};
    return r;
  endfunction

  function automatic row_t cell_row(logic [5:0] i, logic [5:0] j, bit flat);
    row_t r;
    r = '{1'b0, REG_CP0, 64'd0, i, j, flat};
    return r;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(input row_t r);
    rows.insert(rows.size(), r);
  endfunction

  // Check every vertex word against the oldest expectation.
  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && out_strobe) begin
      if (pending_vertices.size() == 0) begin
        report("unexpected vertex, corner", out_corner, -1);
      end else begin
        e = pending_vertices.pop_front();
        if (out_vertex_x !== e.x) report("vertex_x", out_vertex_x, e.x);
        if (out_vertex_y !== e.y) report("vertex_y", out_vertex_y, e.y);
        if (out_vertex_z !== e.z) report("vertex_z", out_vertex_z, e.z);
        if (out_corner !== e.corner) report("corner", out_corner, e.corner);
        if (out_filled !== e.filled) report("filled", out_filled, e.filled);
        if (out_last !== e.last) report("last", out_last, e.last);
      end
    end
  end

  // Watchdog on cycles with no word moving in either direction.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) begin
        quiet <= 0;
      end else if (quiet >= QUIET_MAX) begin
        $display("tb: failure");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    logic [5:0] n_eff;
    logic [5:0] seg_pick;
    logic [63:0] cp;
    for (int k = 0; k < 4; k++) ctrl_pt[k] = '0;
    grid_n = 6'd5;
    fill_on = 1'b0;

    // After reset: flat profile, five segments, then off-grid cells.
    add_row(cell_row(6'd0, 6'd0, 1'b1));
    add_row(cell_row(6'd4, 6'd4, 1'b1));
    add_row(cell_row(6'd5, 6'd0, 1'b0));
    add_row(cell_row(6'd0, 6'd5, 1'b0));
    add_row(cell_row(6'd63, 6'd63, 1'b0));
    // Extreme control points, largest grid, filled mode.
    add_row(wr_row(REG_CP0, 64'hFFFF_7FFF_8000_7FFF));
    add_row(wr_row(REG_CP1, 64'h0000_8000_7FFF_8000));
    add_row(wr_row(REG_CP2, 64'h0000_7FFF_7FFF_7FFF));
    add_row(wr_row(REG_CP3, 64'h0000_8000_8000_8000));
    add_row(wr_row(REG_SEGMENTS, 64'd60));
    add_row(wr_row(REG_FILL, 64'd1));
    add_row(cell_row(6'd0, 6'd0, 1'b0));
    add_row(cell_row(6'd59, 6'd59, 1'b0));
    add_row(cell_row(6'd59, 6'd0, 1'b0));
    add_row(cell_row(6'd0, 6'd59, 1'b0));
    add_row(cell_row(6'd60, 6'd0, 1'b0));
    add_row(cell_row(6'd30, 6'd15, 1'b0));
    // Smallest normal grid.
    add_row(wr_row(REG_SEGMENTS, 64'd4));
    add_row(cell_row(6'd3, 6'd3, 1'b0));
    add_row(cell_row(6'd1, 6'd2, 1'b0));
    // Oversized grid clamps to the maximum.
    add_row(wr_row(REG_SEGMENTS, 64'd63));
    add_row(cell_row(6'd59, 6'd59, 1'b0));
    add_row(cell_row(6'd60, 6'd60, 1'b0));
    // Degenerate grids of one and zero segments.
    add_row(wr_row(REG_SEGMENTS, 64'd1));
    add_row(cell_row(6'd0, 6'd0, 1'b0));
    add_row(wr_row(REG_SEGMENTS, 64'd0));
    add_row(cell_row(6'd0, 6'd0, 1'b0));
    // Unmapped register slot and a return to outline mode.
    add_row(wr_row(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF));
    add_row(wr_row(REG_FILL, 64'd0));
    add_row(wr_row(REG_SEGMENTS, 64'd7));
    add_row(cell_row(6'd6, 6'd6, 1'b0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      if (rows[r].is_write) begin
        drain();
        reg_write(rows[r].idx, rows[r].data);
      end else begin
        send_cell(rows[r].prof, rows[r].ang, rows[r].flat);
      end
    end

    // Random phases, each with fresh registers.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      for (int k = 0; k < 4; k++) begin
        cp = {16'($urandom), pick_coord(), pick_coord(), pick_coord()};
        reg_write(k[2:0], cp);
      end
      case (ph)
        0: seg_pick = 6'd60;
        1: seg_pick = 6'd4;
        2: seg_pick = 6'd63;
        3: seg_pick = 6'd2;
        default: seg_pick = 6'($urandom_range(4, 60));
      endcase
      reg_write(REG_SEGMENTS, {58'($urandom), seg_pick});
      reg_write(REG_FILL, {63'($urandom), 1'($urandom)});
      n_eff = (grid_n > MAX_SEGMENTS) ? 6'(MAX_SEGMENTS) : grid_n;
      for (int c = 0; c < PHASE_CELLS; c++) begin
        if (c == PHASE_CELLS / 2) begin
          // Let the block run dry before carrying on.
          start <= 1'b0;
          do @(posedge clk); while (pending_vertices.size() != 0);
        end
        if ($urandom_range(0, 9) < 8)
          send_cell(6'($urandom_range(0, n_eff - 1)), 6'($urandom_range(0, n_eff - 1)), 1'b0);
        else
          send_cell(6'($urandom), 6'($urandom), 1'b0);
      end
    end

    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/brqg_pkg.sv
rtl/brqg_front.sv
rtl/brqg_div.sv
rtl/brqg_back.sv
rtl/bezier_revolution_quad_gen_top.sv
bench/bezier_revolution_quad_gen_top_test.sv
